// ===== src/bsmsi_pkg.sv =====
// Shared types and constants for the bank switching mapper with scanline IRQ.
// Holds access kind codes, register indexes and the controller/datapath structs.
// No dependencies.
package bsmsi_pkg;

    localparam int MODE_W     = 3;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MAP_W      = 21;
    localparam int PRG_UNIT_W = 8;
    localparam int CHR_UNIT_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int DIVISOR_W  = 9;

    // Remainder unit retires two dividend bits per cycle.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [MODE_W-1:0] MODE_CPU_RD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CPU_WR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GFX_RD = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GFX_WR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SCAN   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_PRG_UNITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHR_UNITS = 2'd1;

    // CPU write register groups, selected by address bits 14:13.
    localparam logic [1:0] GRP_BANK   = 2'd0;
    localparam logic [1:0] GRP_MIRROR = 2'd1;
    localparam logic [1:0] GRP_IRQCNT = 2'd2;
    localparam logic [1:0] GRP_IRQEN  = 2'd3;

    typedef struct packed {
        logic accept;
        logic start;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ===== src/bsmsi_mod.sv =====
// Iterative remainder unit: 8-bit dividend modulo a 9-bit divisor.
// Restoring method, two bits per cycle. Depends on bsmsi_pkg.
module bsmsi_mod (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [bsmsi_pkg::DATA_W-1:0]    i_dividend,
    input  logic [bsmsi_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [bsmsi_pkg::DIVISOR_W-1:0] o_rem
);
    import bsmsi_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_dsr;
    logic [DATA_W-1:0]    r_dvd;
    logic [DIVISOR_W-1:0] s1;
    logic [DIVISOR_W-1:0] s2;

    // One restoring step. The partial remainder stays below the divisor, so it fits.
    function automatic logic [DIVISOR_W-1:0] rem_step(input logic [DIVISOR_W-1:0] rem,
                                                      input logic              dbit,
                                                      input logic [DIVISOR_W-1:0] dsr);
        logic [DIVISOR_W:0] t;
        logic [DIVISOR_W:0] d;
        t = {rem, dbit};
        d = {1'b0, dsr};
        if (t >= d) begin
            t = t - d;
        end
        return t[DIVISOR_W-1:0];
    endfunction

    assign s1     = rem_step(r_rem, r_dvd[DATA_W-1], r_dsr);
    assign s2     = rem_step(s1, r_dvd[DATA_W-2], r_dsr);
    assign o_done = r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= s2;
            r_dvd <= {r_dvd[DATA_W-3:0], 2'b00};
        end
    end

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("remainder unit did not start");
    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !o_done && !i_start) |=> r_busy)
        else $error("remainder unit stopped early");

endmodule

// ===== src/bsmsi_dp.sv =====
// Datapath of the mapper: configuration, mapper registers, IRQ counter,
// window operand selection, remainder unit and the result register. Uses bsmsi_pkg.
module bsmsi_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bsmsi_pkg::t_cmd                  i_cmd,
    output bsmsi_pkg::t_status               o_status,
    input  logic [bsmsi_pkg::MODE_W-1:0]     i_mode,
    input  logic [bsmsi_pkg::ADDR_W-1:0]     i_bus_addr,
    input  logic [bsmsi_pkg::DATA_W-1:0]     i_write_data,
    input  logic                             i_cfg_we,
    input  logic [bsmsi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsmsi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_handled,
    output logic [bsmsi_pkg::MAP_W-1:0]      o_mapped_addr,
    output logic                             o_irq_line,
    output logic                             o_mirror_horizontal,
    output logic                             o_prg_ram_on
);
    import bsmsi_pkg::*;

    // Configuration.
    logic [PRG_UNIT_W-1:0] r_prg_units;
    logic [CHR_UNIT_W-1:0] r_chr_units;

    // Mapper registers.
    logic [2:0]        r_select;
    logic              r_swap;
    logic              r_invert;
    logic [DATA_W-1:0] r_bank [8];
    logic              r_mirror;
    logic              r_ram_en;
    logic              r_irq_en;
    logic              r_reload;
    logic [7:0]        r_reload_val;
    logic [7:0]        r_line;
    logic              r_irq;

    // Latched item.
    logic [MODE_W-1:0] r_mode;
    logic [ADDR_W-1:0] r_addr;

    // Result register.
    logic              r_out_valid;
    logic              r_out_handled;
    logic [MAP_W-1:0]  r_out_addr;
    logic              r_out_irq;
    logic              r_out_mirror;
    logic              r_out_ram;

    logic [7:0]           n_line;
    logic                 cpu_wr;
    logic                 scan;
    logic [PRG_UNIT_W-1:0] units_eff;
    logic [DIVISOR_W-1:0] prg_div;
    logic [DIVISOR_W-1:0] chr_div;
    logic [7:0]           prg_last;
    logic [7:0]           prg_second;
    logic [2:0]           chr_slot;
    logic                 use_pair;
    logic [2:0]           bank_idx;
    logic [DATA_W-1:0]    bank_rd;
    logic [DATA_W-1:0]    dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic                 div_done;
    logic [DIVISOR_W-1:0] rem;
    logic [1:0]           prg_slot;
    logic                 prg_switched;
    logic [7:0]           prg_win;
    logic                 n_handled;
    logic [MAP_W-1:0]     n_mapped;
    logic                 gfx_range;

    // Window divisors; a zero PRG count acts as one unit, a zero CHR count as eight windows.
    assign units_eff  = (r_prg_units == '0) ? PRG_UNIT_W'(1) : r_prg_units;
    assign prg_div    = {units_eff, 1'b0};
    assign prg_last   = {units_eff[6:0], 1'b0} - 8'd1;
    assign prg_second = {units_eff[6:0], 1'b0} - 8'd2;
    assign chr_div    = (r_chr_units == '0) ? DIVISOR_W'(8) : {r_chr_units, 3'b000};

    // Operand selection for the one window the latched access needs.
    assign chr_slot = r_addr[12:10];
    assign use_pair = (chr_slot[2] == r_invert);
    assign prg_slot = r_addr[14:13];
    always_comb begin
        if (r_mode == MODE_CPU_RD) begin
            bank_idx = (prg_slot == 2'd1) ? 3'd7 : 3'd6;
        end else if (use_pair) begin
            bank_idx = {2'b00, chr_slot[1]};
        end else begin
            bank_idx = {1'b0, chr_slot[1:0]} + 3'd2;
        end
    end
    assign bank_rd = r_bank[bank_idx];
    always_comb begin
        if (r_mode == MODE_CPU_RD) begin
            dividend = bank_rd;
            divisor  = prg_div;
        end else begin
            dividend = use_pair ? {bank_rd[7:1], chr_slot[0]} : bank_rd;
            divisor  = chr_div;
        end
    end

    bsmsi_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_rem      (rem)
    );

    // Result formation from the finished remainder.
    assign prg_switched = (prg_slot == 2'd1) || ((prg_slot == 2'd0) && !r_swap) ||
                          ((prg_slot == 2'd2) && r_swap);
    assign prg_win      = prg_switched ? rem[7:0] :
                          ((prg_slot == 2'd3) ? prg_last : prg_second);
    assign gfx_range    = (r_addr[15:13] == 3'b000);
    always_comb begin
        n_handled = 1'b0;
        n_mapped  = '0;
        case (r_mode)
            MODE_CPU_RD: begin
                n_handled = r_addr[15];
                if (r_addr[15]) begin
                    n_mapped = {prg_win, r_addr[12:0]};
                end
            end
            MODE_CPU_WR: begin
                n_handled = r_addr[15];
            end
            MODE_GFX_RD: begin
                n_handled = gfx_range;
                if (gfx_range) begin
                    if (r_chr_units == '0) begin
                        n_mapped = MAP_W'(r_addr);
                    end else begin
                        n_mapped = MAP_W'({rem[7:0], r_addr[9:0]});
                    end
                end
            end
            MODE_GFX_WR: begin
                if (gfx_range && (r_chr_units == '0)) begin
                    n_handled = 1'b1;
                    n_mapped  = MAP_W'(r_addr);
                end
            end
            default: begin
                n_handled = 1'b0;
            end
        endcase
    end

    // Side effects of the accepted item.
    assign cpu_wr = i_cmd.accept && (i_mode == MODE_CPU_WR) && i_bus_addr[15];
    assign scan   = i_cmd.accept && (i_mode == MODE_SCAN);
    assign n_line = ((r_line == 8'd0) || r_reload) ? r_reload_val : (r_line - 8'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_units  <= PRG_UNIT_W'(2);
            r_chr_units  <= CHR_UNIT_W'(1);
            r_select     <= '0;
            r_swap       <= 1'b0;
            r_invert     <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_bank[k] <= '0;
            end
            r_mirror     <= 1'b1;
            r_ram_en     <= 1'b1;
            r_irq_en     <= 1'b0;
            r_reload     <= 1'b0;
            r_reload_val <= '0;
            r_line       <= '0;
            r_irq        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PRG_UNITS: r_prg_units <= i_cfg_data;
                    REG_CHR_UNITS: r_chr_units <= i_cfg_data[CHR_UNIT_W-1:0];
                    default: ;
                endcase
            end
            if (cpu_wr) begin
                case (i_bus_addr[14:13])
                    GRP_BANK: begin
                        if (!i_bus_addr[0]) begin
                            r_select <= i_write_data[2:0];
                            r_swap   <= i_write_data[6];
                            r_invert <= i_write_data[7];
                        end else begin
                            r_bank[r_select] <= i_write_data;
                        end
                    end
                    GRP_MIRROR: begin
                        if (!i_bus_addr[0]) begin
                            r_mirror <= i_write_data[0];
                        end else begin
                            r_ram_en <= i_write_data[7];
                        end
                    end
                    GRP_IRQCNT: begin
                        if (!i_bus_addr[0]) begin
                            r_reload_val <= i_write_data;
                        end else begin
                            r_line   <= '0;
                            r_reload <= 1'b1;
                        end
                    end
                    GRP_IRQEN: begin
                        if (!i_bus_addr[0]) begin
                            r_irq_en <= 1'b0;
                            r_irq    <= 1'b0;
                        end else begin
                            r_irq_en <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (scan) begin
                r_line   <= n_line;
                r_reload <= 1'b0;
                if ((n_line == 8'd0) && r_irq_en) begin
                    r_irq <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_addr <= i_bus_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_handled <= n_handled;
            r_out_addr    <= n_mapped;
            r_out_irq     <= r_irq;
            r_out_mirror  <= r_mirror;
            r_out_ram     <= r_ram_en;
        end
    end

    assign o_status.div_done   = div_done;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_handled           = r_out_handled;
    assign o_mapped_addr       = r_out_addr;
    assign o_irq_line          = r_out_irq;
    assign o_mirror_horizontal = r_out_mirror;
    assign o_prg_ram_on        = r_out_ram;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");
    a_line_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan && (r_line != 8'd0) && !r_reload) |=> (r_line == $past(r_line) - 8'd1))
        else $error("scanline counter did not decrement");

endmodule

// ===== src/bsmsi_ctrl.sv =====
// Controller of the mapper: sequences accept, window remainder and result load.
// Drives the datapath through t_cmd and watches t_status. Uses bsmsi_pkg.
module bsmsi_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output bsmsi_pkg::t_cmd      o_cmd,
    input  bsmsi_pkg::t_status   i_status
);
    import bsmsi_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SETUP;
            S_SETUP: n_state = S_WAIT;
            S_WAIT:  if (i_status.div_done) n_state = S_DONE;
            S_DONE:  if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.start  = (r_state == S_SETUP);
    assign o_cmd.load   = (r_state == S_DONE) && i_status.out_free;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_WAIT))
        else $error("remainder finished outside the wait state");

endmodule

// ===== src/bank_switch_mapper_scanline_irq.sv =====
// An accepted item passes the setup, remainder wait and result load states; the
// next item is accepted only after that load, which waits while the output side
// holds an untaken result. The two-bit-per-cycle remainder unit computes the window.
// Reset: synchronous, active low; mapper registers, IRQ counter and configuration
// return to their power-on values at once, with no clearing pass.
module bank_switch_mapper_scanline_irq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input item channel.
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bsmsi_pkg::MODE_W-1:0]     i_mode,
    input  logic [bsmsi_pkg::ADDR_W-1:0]     i_bus_addr,
    input  logic [bsmsi_pkg::DATA_W-1:0]     i_write_data,
    // Result channel.
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_handled,
    output logic [bsmsi_pkg::MAP_W-1:0]      o_mapped_addr,
    output logic                             o_irq_line,
    output logic                             o_mirror_horizontal,
    output logic                             o_prg_ram_on,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bsmsi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsmsi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bsmsi_pkg::*;

    // The controller owns sequencing only; every register of the mapper lives
    // in the datapath. Window numbers are never stored: each read computes the
    // single window it needs from the current bank values and configuration,
    // which gives the same answer as recomputing all windows on every change.
    t_cmd    cmd;
    t_status status;

    // Always taken; the user sends configuration transactions only while idle.
    assign o_cfg_ready = 1'b1;

    bsmsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // The datapath applies CPU writes and scanline clocks at acceptance, then
    // the remainder unit produces the window for reads. The result register
    // decouples the output side, so a new transaction may be accepted while
    // the previous result still waits to be taken.
    bsmsi_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_mode              (i_mode),
        .i_bus_addr          (i_bus_addr),
        .i_write_data        (i_write_data),
        .i_cfg_we            (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_handled           (o_handled),
        .o_mapped_addr       (o_mapped_addr),
        .o_irq_line          (o_irq_line),
        .o_mirror_horizontal (o_mirror_horizontal),
        .o_prg_ram_on        (o_prg_ram_on)
    );

endmodule
